/* sv/vtrc_pkg.sv */
// vtrc_pkg: shared types, constants, palette tables and the divider step
// for the value_to_rgb_colormap block. No dependencies.
package vtrc_pkg;

    localparam int VALUE_BITS     = 24;
    localparam int FRACTION_BITS  = 16;
    localparam int CHANNELS       = 3;
    localparam int PALETTE_POINTS = 5;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int CFG_INDEX_BITS = 2;
    // Interpolation product: fraction (FRACTION_BITS+2 signed) times 9-bit delta
    localparam int PROD_BITS      = FRACTION_BITS + 11;

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [VALUE_BITS-1:0]        mag_t;
    typedef logic [FRACTION_BITS:0]       frac_t;
    typedef logic [7:0]                   chan_t;
    typedef logic signed [8:0]            delta_t;
    typedef logic [CFG_INDEX_BITS-1:0]    cfg_index_t;

    // Register indexes on the configuration port
    localparam cfg_index_t CFG_RANGE_LOW  = cfg_index_t'(0);
    localparam cfg_index_t CFG_RANGE_HIGH = cfg_index_t'(1);
    localparam cfg_index_t CFG_MAP_SELECT = cfg_index_t'(2);

    localparam value_t RANGE_LOW_RESET  = value_t'(0);
    localparam value_t RANGE_HIGH_RESET = value_t'(1000);

    // Fixed-point fraction constants, 1.0 = 2^FRACTION_BITS
    localparam frac_t T_ONE     = frac_t'(2 ** FRACTION_BITS);
    localparam frac_t T_QUARTER = frac_t'(2 ** (FRACTION_BITS - 2));
    localparam frac_t T_HALF    = frac_t'(2 ** (FRACTION_BITS - 1));
    localparam frac_t T_3QUART  = frac_t'(3 * 2 ** (FRACTION_BITS - 2));

    // How the back end forms t for an item
    typedef enum logic [1:0] {
        CLS_ZERO, // empty or inverted range, or sample at/below low: t = 0
        CLS_ONE,  // sample at/above high: t = 1
        CLS_DIV   // inside the range: t from the divider
    } cls_t;

    // One queued item, already classified
    typedef struct packed {
        cls_t cls;
        logic pal;
        mag_t diff;
        mag_t span;
    } item_t;

    typedef struct packed {
        logic qbit;
        mag_t rem;
    } div_step_t;

    // Five-point palettes: viridis, cividis
    localparam chan_t PALETTE [2][PALETTE_POINTS][CHANNELS] = '{
        '{ '{8'd68,  8'd1,   8'd84},  '{8'd59,  8'd82,  8'd139},
           '{8'd33,  8'd145, 8'd140}, '{8'd94,  8'd201, 8'd98},
           '{8'd253, 8'd231, 8'd37} },
        '{ '{8'd0,   8'd32,  8'd76},  '{8'd35,  8'd53,  8'd102},
           '{8'd86,  8'd73,  8'd115}, '{8'd144, 8'd91,  8'd109},
           '{8'd222, 8'd137, 8'd96} }
    };

    // One restoring division step: remainder stays below span
    function automatic div_step_t div_step(input mag_t rem, input mag_t span);
        logic [VALUE_BITS:0] shifted;
        div_step_t           res;
        shifted = {rem, 1'b0};
        if (shifted >= {1'b0, span})
        begin
            res.qbit = 1'b1;
            res.rem  = mag_t'(shifted - {1'b0, span});
        end
        else
        begin
            res.qbit = 1'b0;
            res.rem  = shifted[VALUE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

/* sv/vtrc_if.sv */
// vtrc_if: valid/ready channel interfaces for samples in and colors out.
// Depends on vtrc_pkg.
interface vtrc_sample_if;
    import vtrc_pkg::*;
    logic   valid;
    logic   ready;
    value_t sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface vtrc_color_if;
    import vtrc_pkg::*;
    logic  valid;
    logic  ready;
    chan_t red;
    chan_t green;
    chan_t blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* sv/vtrc_front.sv */
// vtrc_front: accepts samples, classifies them against the configured range
// and hands the item to the queue. Depends on vtrc_pkg, vtrc_if.
module vtrc_front (
    vtrc_sample_if.sink      sample,
    input  vtrc_pkg::value_t range_low,
    input  vtrc_pkg::value_t range_high,
    input  logic             map_select,
    input  logic             full,
    output logic             push,
    output vtrc_pkg::item_t  push_item
);
    import vtrc_pkg::*;

    logic signed [VALUE_BITS:0] span_wide;
    logic signed [VALUE_BITS:0] diff_wide;
    logic signed [VALUE_BITS:0] over_wide;
    logic                       flat;
    logic                       below;
    logic                       above;

    assign sample.ready = !full;
    assign push         = sample.valid && !full;

    // Three parallel subtracts give all range tests
    always_comb
    begin
        span_wide = $signed({range_high[VALUE_BITS-1], range_high})
                  - $signed({range_low[VALUE_BITS-1], range_low});
        diff_wide = $signed({sample.sample_value[VALUE_BITS-1], sample.sample_value})
                  - $signed({range_low[VALUE_BITS-1], range_low});
        over_wide = $signed({sample.sample_value[VALUE_BITS-1], sample.sample_value})
                  - $signed({range_high[VALUE_BITS-1], range_high});
        flat  = span_wide[VALUE_BITS] || (span_wide == '0);
        below = diff_wide[VALUE_BITS] || (diff_wide == '0);
        above = !over_wide[VALUE_BITS];
    end

    // Build the queued item
    always_comb
    begin
        if (flat || below)
            push_item.cls = CLS_ZERO;
        else if (above)
            push_item.cls = CLS_ONE;
        else
            push_item.cls = CLS_DIV;
        push_item.pal  = map_select;
        push_item.diff = diff_wide[VALUE_BITS-1:0];
        push_item.span = span_wide[VALUE_BITS-1:0];
    end

endmodule

/* sv/vtrc_queue.sv */
// vtrc_queue: short FIFO of classified items between front and back end.
// Depends on vtrc_pkg.
module vtrc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vtrc_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output vtrc_pkg::item_t head
);
    import vtrc_pkg::*;

    item_t                     entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg;

    assign full  = (count_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_BITS'(1);
            if (push && !pop)
                count_reg <= count_reg + (QUEUE_PTR_BITS+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QUEUE_PTR_BITS+1)'(1);
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* sv/vtrc_back.sv */
// vtrc_back: pipelined divider (one quotient bit per stage), segment pick,
// per-channel multiply and output register. Depends on vtrc_pkg, vtrc_if.
module vtrc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  vtrc_pkg::item_t head,
    input  logic            empty,
    output logic            pop,
    vtrc_color_if.source    color
);
    import vtrc_pkg::*;

    logic en;

    // Divider stages
    logic [FRACTION_BITS-1:0] div_vld_reg;
    cls_t                     div_cls_reg  [FRACTION_BITS];
    logic                     div_pal_reg  [FRACTION_BITS];
    mag_t                     div_rem_reg  [FRACTION_BITS];
    mag_t                     div_span_reg [FRACTION_BITS];
    logic [FRACTION_BITS-1:0] div_q_reg    [FRACTION_BITS];
    div_step_t                step         [FRACTION_BITS];
    logic [FRACTION_BITS-1:0] div_q_next   [FRACTION_BITS];

    // Segment stage
    logic   seg_vld_reg;
    frac_t  seg_frac4_reg;
    chan_t  seg_start_reg [CHANNELS];
    delta_t seg_delta_reg [CHANNELS];
    frac_t  t;
    logic [1:0] seg;
    frac_t  offset;
    frac_t  seg_frac4_next;
    chan_t  seg_start_next [CHANNELS];
    delta_t seg_delta_next [CHANNELS];

    // Multiply stage
    logic                        mul_vld_reg;
    logic signed [PROD_BITS-1:0] mul_prod_reg  [CHANNELS];
    chan_t                       mul_start_reg [CHANNELS];
    logic signed [PROD_BITS-1:0] mul_prod_next [CHANNELS];

    // Output register
    logic                        out_vld_reg;
    chan_t                       out_chan_reg  [CHANNELS];
    logic signed [10:0]          out_sum       [CHANNELS];

    // Whole pipeline advances when the output slot is free or being taken
    assign en  = !out_vld_reg || color.ready;
    assign pop = en && !empty;

    assign color.valid = out_vld_reg;
    assign color.red   = out_chan_reg[0];
    assign color.green = out_chan_reg[1];
    assign color.blue  = out_chan_reg[2];

    // Divider step per stage
    always_comb
    begin
        step[0]       = div_step(head.diff, head.span);
        div_q_next[0] = {{(FRACTION_BITS-1){1'b0}}, step[0].qbit};
        for (int s = 1; s < FRACTION_BITS; s++)
        begin
            step[s]       = div_step(div_rem_reg[s-1], div_span_reg[s-1]);
            div_q_next[s] = {div_q_reg[s-1][FRACTION_BITS-2:0], step[s].qbit};
        end
    end

    // Segment select and palette lookup
    always_comb
    begin
        case (div_cls_reg[FRACTION_BITS-1])
            CLS_ONE: t = T_ONE;
            CLS_DIV: t = {1'b0, div_q_reg[FRACTION_BITS-1]};
            default: t = '0;
        endcase
        if (t <= T_QUARTER)
            seg = 2'd0;
        else if (t <= T_HALF)
            seg = 2'd1;
        else if (t <= T_3QUART)
            seg = 2'd2;
        else
            seg = 2'd3;
        offset         = t - (frac_t'(seg) << (FRACTION_BITS - 2));
        seg_frac4_next = {offset[FRACTION_BITS-2:0], 2'b00};
        for (int c = 0; c < CHANNELS; c++)
        begin
            seg_start_next[c] = PALETTE[div_pal_reg[FRACTION_BITS-1]][{1'b0, seg}][c];
            seg_delta_next[c] =
                $signed({1'b0, PALETTE[div_pal_reg[FRACTION_BITS-1]][{1'b0, seg} + 3'd1][c]})
                - $signed({1'b0, seg_start_next[c]});
        end
    end

    // Interpolation product and final add
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            mul_prod_next[c] = PROD_BITS'($signed({1'b0, seg_frac4_reg}))
                             * PROD_BITS'(seg_delta_reg[c]);
            out_sum[c] = $signed({3'b000, mul_start_reg[c]})
                       + $signed(mul_prod_reg[c][PROD_BITS-1:FRACTION_BITS]);
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_vld_reg <= '0;
            seg_vld_reg <= 1'b0;
            mul_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            div_vld_reg <= {div_vld_reg[FRACTION_BITS-2:0], !empty};
            seg_vld_reg <= div_vld_reg[FRACTION_BITS-1];
            mul_vld_reg <= seg_vld_reg;
            out_vld_reg <= mul_vld_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_cls_reg[0]  <= head.cls;
            div_pal_reg[0]  <= head.pal;
            div_span_reg[0] <= head.span;
            div_rem_reg[0]  <= step[0].rem;
            div_q_reg[0]    <= div_q_next[0];
            for (int s = 1; s < FRACTION_BITS; s++)
            begin
                div_cls_reg[s]  <= div_cls_reg[s-1];
                div_pal_reg[s]  <= div_pal_reg[s-1];
                div_span_reg[s] <= div_span_reg[s-1];
                div_rem_reg[s]  <= step[s].rem;
                div_q_reg[s]    <= div_q_next[s];
            end
            seg_frac4_reg <= seg_frac4_next;
            for (int c = 0; c < CHANNELS; c++)
            begin
                seg_start_reg[c] <= seg_start_next[c];
                seg_delta_reg[c] <= seg_delta_next[c];
                mul_start_reg[c] <= seg_start_reg[c];
                mul_prod_reg[c]  <= mul_prod_next[c];
                out_chan_reg[c]  <= out_sum[c][7:0];
            end
        end
    end

endmodule

/* sv/value_to_rgb_colormap.sv */
// value_to_rgb_colormap: maps a signed sample to an RGB color over a viridis or cividis ramp.
// Path from sample accept to color valid: queue slot, one divider stage per quotient bit,
// segment, multiply, output. Throughput: one item per cycle when output is not stalled;
// the four-entry queue keeps taking items while output stalls.
// Reset: range_low 0, range_high 1000, viridis selected; queue and pipeline empty.
// Depends on vtrc_pkg, vtrc_if, vtrc_front, vtrc_queue, vtrc_back.
module value_to_rgb_colormap (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  vtrc_pkg::cfg_index_t   cfg_index,
    input  vtrc_pkg::value_t       cfg_data,
    vtrc_sample_if.sink            sample,
    vtrc_color_if.source           color
);
    import vtrc_pkg::*;

    value_t range_low_reg;
    value_t range_high_reg;
    logic   map_select_reg;

    logic   push;
    item_t  push_item;
    logic   q_full;
    logic   q_empty;
    logic   pop;
    item_t  head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= RANGE_LOW_RESET;
            range_high_reg <= RANGE_HIGH_RESET;
            map_select_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RANGE_LOW:  range_low_reg  <= cfg_data;
                CFG_RANGE_HIGH: range_high_reg <= cfg_data;
                CFG_MAP_SELECT: map_select_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    vtrc_front u_front (
        .sample     (sample),
        .range_low  (range_low_reg),
        .range_high (range_high_reg),
        .map_select (map_select_reg),
        .full       (q_full),
        .push       (push),
        .push_item  (push_item)
    );

    vtrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (head)
    );

    vtrc_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (q_empty),
        .pop   (pop),
        .color (color)
    );

    // Queue bookkeeping checks
    assert property (@(posedge clk) disable iff (!rst_n) q_empty && !push |=> q_empty)
        else $error("queue left empty without a push");
    assert property (@(posedge clk) disable iff (!rst_n) q_full && !pop |=> q_full)
        else $error("queue left full without a pop");
    assert property (@(posedge clk) disable iff (!rst_n) $fell(sample.ready) |-> $past(push && !pop))
        else $error("input stalled without the queue filling");

endmodule

/* test/testbench.sv */
// testbench: self-checking bench for value_to_rgb_colormap. It drives samples across many
// register windows and checks every color against its own fixed-point predictor.
// Depends on vtrc_pkg, vtrc_if and the value_to_rgb_colormap RTL.
module testbench;
    import vtrc_pkg::*;

    localparam int     NUM_PHASES      = 10;
    localparam int     ITEMS_PER_PHASE = 80;
    localparam int     IDLE_LIMIT      = 2000;
    localparam int     TAIL_CYCLES     = FRACTION_BITS + 3 + 12;
    localparam int     REPORT_MAX      = 10;
    localparam longint T_FULL          = longint'(1) << FRACTION_BITS;
    localparam longint T_QTR           = T_FULL >> 2;
    localparam longint VALUE_MIN       = -(longint'(1) << (VALUE_BITS - 1));
    localparam longint VALUE_MAX       = (longint'(1) << (VALUE_BITS - 1)) - 1;

    // Index past the register list; writes to it must be ignored
    localparam cfg_index_t CFG_SPARE = cfg_index_t'(3);

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_PATTERN,
        RDY_LONG
    } recv_mode_t;

    typedef struct packed {
        value_t sample;
        chan_t  red;
        chan_t  green;
        chan_t  blue;
    } color_exp_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_write;
    cfg_index_t cfg_index;
    value_t     cfg_data;

    vtrc_sample_if sample_ch ();
    vtrc_color_if  color_ch ();

    value_to_rgb_colormap dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .color     (color_ch)
    );

    always #5 clk = ~clk;

    // Shadow copy of the register file
    value_t     win_low  = RANGE_LOW_RESET;
    value_t     win_high = RANGE_HIGH_RESET;
    logic       use_cividis = 1'b0;

    value_t     samples_pending [$];
    color_exp_t colors_due [$];
    int         issued   = 0;
    int         accepted = 0;
    int         checked  = 0;
    int         errors   = 0;
    int         windows  = 0;
    recv_mode_t recv_mode = RDY_ALWAYS;
    bit         bursty = 1'b1;

    // Five-point ramps, packed as {red, green, blue}
    function automatic logic [23:0] ramp_point(input logic cividis, input int idx);
        if (!cividis)
        begin
            case (idx)
                0:       return {8'd68, 8'd1, 8'd84};
                1:       return {8'd59, 8'd82, 8'd139};
                2:       return {8'd33, 8'd145, 8'd140};
                3:       return {8'd94, 8'd201, 8'd98};
                default: return {8'd253, 8'd231, 8'd37};
            endcase
        end
        case (idx)
            0:       return {8'd0, 8'd32, 8'd76};
            1:       return {8'd35, 8'd53, 8'd102};
            2:       return {8'd86, 8'd73, 8'd115};
            3:       return {8'd144, 8'd91, 8'd109};
            default: return {8'd222, 8'd137, 8'd96};
        endcase
    endfunction

    // Normalize the sample into t, pick the segment, interpolate each channel
    function automatic color_exp_t map_sample(input value_t v);
        longint      lo;
        longint      hi;
        longint      sv;
        longint      t;
        longint      frac4;
        longint      c0;
        longint      c1;
        longint      total;
        int          seg;
        int          ch;
        logic [23:0] p0;
        logic [23:0] p1;
        logic [23:0] mix;
        color_exp_t  res;
        lo = longint'(win_low);
        hi = longint'(win_high);
        sv = longint'(v);
        res.sample = v;
        if (hi <= lo)
        begin
            // empty or inverted window: first ramp color
            {res.red, res.green, res.blue} = ramp_point(use_cividis, 0);
            return res;
        end
        if (sv <= lo)
            t = 0;
        else if (sv >= hi)
            t = T_FULL;
        else
            t = ((sv - lo) << FRACTION_BITS) / (hi - lo);
        // boundaries belong to the lower segment
        if (t <= T_QTR)
            seg = 0;
        else if (t <= 2 * T_QTR)
            seg = 1;
        else if (t <= 3 * T_QTR)
            seg = 2;
        else
            seg = 3;
        frac4 = (t - seg * T_QTR) * 4;
        p0 = ramp_point(use_cividis, seg);
        p1 = ramp_point(use_cividis, seg + 1);
        for (ch = 0; ch < 3; ch++)
        begin
            c0 = longint'(p0[23 - 8 * ch -: 8]);
            c1 = longint'(p1[23 - 8 * ch -: 8]);
            total = (c0 << FRACTION_BITS) + frac4 * (c1 - c0);
            if (total < 0)
                total = 0;
            mix[23 - 8 * ch -: 8] = 8'((total >> FRACTION_BITS) & 255);
        end
        {res.red, res.green, res.blue} = mix;
        return res;
    endfunction

    function automatic value_t to_value(input longint x);
        if (x < VALUE_MIN)
            return value_t'(VALUE_MIN);
        if (x > VALUE_MAX)
            return value_t'(VALUE_MAX);
        return value_t'(x);
    endfunction

    // Mostly in-window samples, some near edges and quarter points, some anywhere
    function automatic value_t draw_sample();
        longint lo;
        longint span;
        int     pick;
        lo   = longint'(win_low);
        span = longint'(win_high) - lo;
        pick = $urandom_range(0, 9);
        if (span <= 0 || pick >= 8)
            return value_t'($urandom);
        if (pick <= 5)
            return to_value(lo + longint'($urandom) % (span + 1));
        if (pick == 6)
            return to_value(lo + (span * $urandom_range(0, 4)) / 4
                            + $urandom_range(0, 2) - 1);
        if ($urandom_range(0, 1) == 0)
            return to_value(lo - $urandom_range(0, 1000));
        return to_value(longint'(win_high) + $urandom_range(0, 1000));
    endfunction

    task automatic write_reg(input cfg_index_t idx, input value_t data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_RANGE_LOW:  win_low = data;
            CFG_RANGE_HIGH: win_high = data;
            CFG_MAP_SELECT: use_cividis = data[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Block is idle once every sample is taken and every color has come back
    task automatic wait_idle();
        while (samples_pending.size() != 0 || issued != accepted || colors_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Sample driver: bursts of random length, separated by random gaps in bursty phases
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid        <= 1'b0;
            sample_ch.sample_value <= '0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                colors_due.push_back(map_sample(sample_ch.sample_value));
                accepted++;
            end
            if (sample_ch.valid && !sample_ch.ready)
            begin
                // hold the item until it is taken
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                sample_ch.valid <= 1'b0;
            end
            else if (samples_pending.size() != 0)
            begin
                sample_ch.valid        <= 1'b1;
                sample_ch.sample_value <= samples_pending.pop_front();
                issued++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = bursty ? $urandom_range(0, 8) : 0;
                end
            end
            else
            begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    // Color monitor: stall pattern depends on the phase, check against oldest expectation
    int stall_tick = 0;
    int stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_ch.ready <= 1'b0;
        end
        else
        begin
            if (color_ch.valid && color_ch.ready)
            begin
                if (colors_due.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("unexpected color %0d/%0d/%0d with nothing pending",
                                 color_ch.red, color_ch.green, color_ch.blue);
                end
                else
                begin
                    color_exp_t want;
                    want = colors_due.pop_front();
                    checked++;
                    if (color_ch.red !== want.red || color_ch.green !== want.green ||
                        color_ch.blue !== want.blue)
                    begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $display({"mismatch: sample %0d window %0d..%0d ",
                                      "expected %0d/%0d/%0d got %0d/%0d/%0d"},
                                     want.sample, win_low, win_high, want.red, want.green,
                                     want.blue, color_ch.red, color_ch.green, color_ch.blue);
                    end
                end
            end
            case (recv_mode)
                RDY_ALWAYS:
                    color_ch.ready <= 1'b1;
                RDY_COIN:
                    color_ch.ready <= 1'($urandom_range(0, 1));
                RDY_PATTERN:
                begin
                    stall_tick = (stall_tick + 1) % 8;
                    color_ch.ready <= (stall_tick >= 3);
                end
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        color_ch.ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 19) == 0)
                    begin
                        stall_left = $urandom_range(5, 30);
                        color_ch.ready <= 1'b0;
                    end
                    else
                    begin
                        color_ch.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Watchdog: too long without any item moving on either channel
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (color_ch.valid && color_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus: directed edges first, then random samples over many windows
    initial
    begin
        int     p;
        int     n;
        longint lo;
        longint span;
        cfg_write              = 1'b0;
        cfg_index              = CFG_RANGE_LOW;
        cfg_data               = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.sample_value = '0;
        color_ch.ready         = 1'b0;
        rst_n                  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window 0..1000: extremes, quarter points exact and either side
        recv_mode = RDY_PATTERN;
        windows++;
        samples_pending = '{value_t'(VALUE_MIN), value_t'(VALUE_MAX), 0, -1, 1,
                            250, 249, 251, 500, 499, 501, 750, 749, 751,
                            125, 875, 999, 1000, 1001};
        wait_idle();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                    write_reg(CFG_MAP_SELECT, value_t'(1));
                1:
                begin
                    write_reg(CFG_RANGE_LOW, value_t'(VALUE_MIN));
                    write_reg(CFG_RANGE_HIGH, value_t'(VALUE_MAX));
                    write_reg(CFG_MAP_SELECT, value_t'(24'hFFFFFE));
                end
                2:
                begin
                    // inverted window
                    write_reg(CFG_RANGE_LOW, value_t'(100));
                    write_reg(CFG_RANGE_HIGH, value_t'(-100));
                    write_reg(CFG_MAP_SELECT, value_t'(1));
                end
                3:
                begin
                    // empty window
                    write_reg(CFG_RANGE_LOW, value_t'(12345));
                    write_reg(CFG_RANGE_HIGH, value_t'(12345));
                    write_reg(CFG_MAP_SELECT, value_t'(0));
                end
                4:
                begin
                    write_reg(CFG_SPARE, value_t'($urandom));
                    write_reg(CFG_RANGE_LOW, value_t'(-5));
                    write_reg(CFG_RANGE_HIGH, value_t'(-1));
                    write_reg(CFG_MAP_SELECT, value_t'(1));
                end
                5:
                begin
                    write_reg(CFG_RANGE_LOW, value_t'(VALUE_MIN));
                    write_reg(CFG_RANGE_HIGH, value_t'(VALUE_MIN + 1));
                    write_reg(CFG_MAP_SELECT, value_t'(0));
                end
                6:
                begin
                    write_reg(CFG_RANGE_LOW, value_t'(VALUE_MAX - 1));
                    write_reg(CFG_RANGE_HIGH, value_t'(VALUE_MAX));
                    write_reg(CFG_MAP_SELECT, value_t'(1));
                end
                default:
                begin
                    lo   = longint'(value_t'($urandom));
                    span = $urandom_range(1, 1 << $urandom_range(1, 23));
                    if ($urandom_range(0, 5) == 0)
                        span = -span;
                    write_reg(CFG_RANGE_LOW, value_t'(lo));
                    write_reg(CFG_RANGE_HIGH, to_value(lo + span));
                    write_reg(CFG_MAP_SELECT, value_t'($urandom));
                end
            endcase
            recv_mode = recv_mode_t'(p % 4);
            bursty    = (p % 3) != 0;
            windows++;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                samples_pending.push_back(draw_sample());
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (colors_due.size() != 0)
            errors++;
        $display("covered %0d samples over %0d register windows, both palettes, four stall modes",
                 accepted, windows);
        $display("%0d colors checked, %0d mismatches", checked, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
